// ===== hw/rtl/phase_tick_gap_filler_defines.svh =====
// Assertion macros for the phase tick gap filler.
// Uses the clk and rst_n names of the including module; no other dependencies.
`ifndef PHASE_TICK_GAP_FILLER_DEFINES_SVH
`define PHASE_TICK_GAP_FILLER_DEFINES_SVH

`ifndef SYNTHESIS
`define PTGF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptgf assertion failed");
`define PTGF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptgf assertion failed");
`else
`define PTGF_ASSERT_IMP(label, ante, cons)
`define PTGF_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== hw/rtl/ptgf_pkg.sv =====
// Shared constants, state type and controller/datapath interface structs
// for the phase tick gap filler. No dependencies.
`timescale 1ns / 1ps

package ptgf_pkg;

    localparam int PHASE_W   = 10;
    localparam int TICK_W    = 9;
    localparam int WRAP_SIZE = 360;
    localparam int MAX_BURST = 20;
    localparam int CNT_W     = $clog2(MAX_BURST + 1);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_BURST
    } ptgf_state_t;

    typedef struct packed {
        logic load;   // request accepted: latch burst setup and update history
        logic emit;   // move the next tick into the output register
    } ptgf_cmd_t;

    typedef struct packed {
        logic has_burst;   // current request produces at least one tick
        logic final_tick;  // one tick left in the running burst
        logic slot_free;   // output register can take a tick this cycle
    } ptgf_status_t;

endpackage

// ===== hw/rtl/ptgf_ctrl.sv =====
// Controller state machine for the phase tick gap filler.
// Depends on ptgf_pkg.
`timescale 1ns / 1ps

module ptgf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  phase_valid,
    output logic                  phase_stall,
    input  ptgf_pkg::ptgf_status_t status,
    output ptgf_pkg::ptgf_cmd_t    cmd
);
    import ptgf_pkg::*;

    ptgf_state_t state_reg;
    ptgf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        phase_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                phase_stall = 1'b0;
                if (phase_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.has_burst)
                    begin
                        state_next = ST_BURST;
                    end
                end
            end
            ST_BURST:
            begin
                if (status.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.final_tick)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/ptgf_datapath.sv =====
// Datapath for the phase tick gap filler: history, burst setup, tick stepper
// and output register. Depends on ptgf_pkg.
`timescale 1ns / 1ps

module ptgf_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [ptgf_pkg::PHASE_W-1:0]   phase,
    input  ptgf_pkg::ptgf_cmd_t            cmd,
    output ptgf_pkg::ptgf_status_t         status,
    output logic                           tick_valid,
    input  logic                           tick_stall,
    output logic [ptgf_pkg::TICK_W-1:0]    tick,
    output logic                           last_of_burst
);
    import ptgf_pkg::*;

    logic [TICK_W-1:0] prev_reg;
    logic              first_reg;
    logic [TICK_W-1:0] step_reg;
    logic [CNT_W-1:0]  remain_reg;
    logic              wrap_reg;
    logic              out_valid_reg;
    logic [TICK_W-1:0] out_tick_reg;
    logic              out_last_reg;

    logic [TICK_W-1:0] cur;
    logic              neg;
    logic [TICK_W:0]   fwd_amt;
    logic [TICK_W:0]   back_amt;
    logic signed [TICK_W+1:0] wrap_cnt;
    logic [TICK_W:0]   prev_inc;
    logic [TICK_W-1:0] start_tick;
    logic [CNT_W-1:0]  start_cnt;
    logic              start_wrap;
    logic [TICK_W-1:0] step_next;

    assign neg      = phase[PHASE_W-1];
    assign cur      = phase[TICK_W-1:0];
    assign fwd_amt  = {1'b0, cur} - {1'b0, prev_reg};
    assign back_amt = {1'b0, prev_reg} - {1'b0, cur};
    assign wrap_cnt = $signed((TICK_W+2)'(WRAP_SIZE)) - $signed({1'b0, back_amt});
    assign prev_inc = {1'b0, prev_reg} + (TICK_W+1)'(1);

    // Burst setup for the request on the input port
    always_comb
    begin
        start_tick = cur;
        start_cnt  = '0;
        start_wrap = 1'b0;
        if (neg)
        begin
            start_cnt = '0;
        end
        else if (first_reg && (cur == '0))
        begin
            start_tick = '0;
            start_cnt  = CNT_W'(1);
        end
        else if (cur == prev_reg)
        begin
            start_cnt = '0;
        end
        else if ((cur > prev_reg) && (fwd_amt > (TICK_W+1)'(1)))
        begin
            start_tick = prev_inc[TICK_W-1:0];
            start_cnt  = (fwd_amt > (TICK_W+1)'(MAX_BURST)) ? CNT_W'(MAX_BURST)
                                                             : fwd_amt[CNT_W-1:0];
        end
        else if ((cur < prev_reg) && (back_amt != (TICK_W+1)'(WRAP_SIZE - 1)))
        begin
            start_wrap = 1'b1;
            start_tick = (prev_inc >= (TICK_W+1)'(WRAP_SIZE))
                       ? TICK_W'(prev_inc - (TICK_W+1)'(WRAP_SIZE))
                       : prev_inc[TICK_W-1:0];
            if (wrap_cnt <= $signed((TICK_W+2)'(0)))
            begin
                start_cnt = '0;
            end
            else if (wrap_cnt > $signed((TICK_W+2)'(MAX_BURST)))
            begin
                start_cnt = CNT_W'(MAX_BURST);
            end
            else
            begin
                start_cnt = wrap_cnt[CNT_W-1:0];
            end
        end
        else
        begin
            start_tick = cur;
            start_cnt  = CNT_W'(1);
        end
    end

    // Advance by one, rolling over at the wrap size only in wrap bursts
    assign step_next = (wrap_reg && (step_reg == TICK_W'(WRAP_SIZE - 1)))
                     ? '0 : step_reg + TICK_W'(1);

    assign status.has_burst  = (start_cnt != '0);
    assign status.final_tick = (remain_reg == CNT_W'(1));
    assign status.slot_free  = !out_valid_reg || !tick_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            first_reg     <= 1'b1;
            remain_reg    <= '0;
            wrap_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                remain_reg <= start_cnt;
                wrap_reg   <= start_wrap;
                if (!neg)
                begin
                    first_reg <= 1'b0;
                    prev_reg  <= cur;
                end
            end
            else if (cmd.emit)
            begin
                remain_reg <= remain_reg - CNT_W'(1);
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !tick_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            step_reg <= start_tick;
        end
        else if (cmd.emit)
        begin
            step_reg <= step_next;
        end

        if (cmd.emit)
        begin
            out_tick_reg <= step_reg;
            out_last_reg <= (remain_reg == CNT_W'(1));
        end
    end

    assign tick_valid    = out_valid_reg;
    assign tick          = out_tick_reg;
    assign last_of_burst = out_last_reg;

endmodule

// ===== hw/rtl/phase_tick_gap_filler.sv =====
// Phase tick gap filler: top level joining the controller and the datapath.
// Depends on ptgf_pkg, ptgf_ctrl, ptgf_datapath and the assertion macro header.
`timescale 1ns / 1ps
`include "phase_tick_gap_filler_defines.svh"

// Accepts one signed phase tick per request and emits, one per cycle unless
// tick_stall holds the output, the ticks after the previous non-negative
// request up to the new one, with last_of_burst set on the final tick of each
// burst. Negative requests and repeats emit nothing; the first request after
// reset with value zero emits a single zero. Forward gaps emit previous+1 up
// to the new value; backward jumps roll over modulo WRAP_SIZE (360), except a
// jump of exactly -(WRAP_SIZE-1), which emits only the new value. Bursts are
// capped at MAX_BURST (20) ticks. Handshake: a request is taken while the
// controller is idle; a request producing ticks then holds phase_stall high
// while the tick stepper feeds the output register, and longer while the
// output side stalls. A request producing no tick leaves the controller idle.
// The output register lets the last tick of a burst wait on tick_stall while
// the next request is taken.

module phase_tick_gap_filler (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         phase_valid,
    output logic                         phase_stall,
    input  logic [ptgf_pkg::PHASE_W-1:0] phase,
    output logic                         tick_valid,
    input  logic                         tick_stall,
    output logic [ptgf_pkg::TICK_W-1:0]  tick,
    output logic                         last_of_burst
);
    import ptgf_pkg::*;

    ptgf_cmd_t    cmd;
    ptgf_status_t status;

    // Sequence each request: take it, then step out its burst
    ptgf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .phase_valid (phase_valid),
        .phase_stall (phase_stall),
        .status      (status),
        .cmd         (cmd)
    );

    // Hold history, set up the burst and drive the output register
    ptgf_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .phase         (phase),
        .cmd           (cmd),
        .status        (status),
        .tick_valid    (tick_valid),
        .tick_stall    (tick_stall),
        .tick          (tick),
        .last_of_burst (last_of_burst)
    );

    // A tick that is not the last of its burst means the burst still runs
    `PTGF_ASSERT_IMP(a_mid_burst_blocks_input, tick_valid && !last_of_burst, phase_stall)
    // Emitting the final tick returns the controller to taking requests
    `PTGF_ASSERT_NXT(a_final_returns_idle, cmd.emit && status.final_tick, !phase_stall)
    // A negative request starts no burst
    `PTGF_ASSERT_NXT(a_negative_no_burst, phase_valid && !phase_stall && phase[PHASE_W-1], !phase_stall)

endmodule
